FILE: sv/im2col_pkg.sv
// ============================================================================
// im2col_pkg: shared types and constants of the im2col patch gatherer
// Holds the field widths, register indexes, controller states and the
// command and status bundles that pass between controller and datapath.
// ============================================================================
package im2col_pkg;

    // Field widths of the stream payloads.
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 64;
    localparam int LOAD_ADDR_W = 12;
    localparam int WORD_W      = 32;
    localparam int ROW_W       = 14;
    localparam int COL_W       = 16;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_WIDTH     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_HEIGHT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_WIDTH  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_HEIGHT = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_PAIR   = 3'd7;

    // Request kinds carried on the input tuser.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    // Register limits.
    localparam logic [8:0] DIM_MAX = 9'd256;
    localparam logic [6:0] CH_MAX  = 7'd64;
    localparam logic [4:0] WIN_MAX = 5'd16;

    // Offset count width and divider length.
    localparam int CNT_W     = 9;
    localparam int DIV_STEPS = 9;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_DIVX  = 11'b000_0000_0010,
        S_WAITX = 11'b000_0000_0100,
        S_DIVY  = 11'b000_0000_1000,
        S_WAITY = 11'b000_0001_0000,
        S_CHECK = 11'b000_0010_0000,
        S_MUL   = 11'b000_0100_0000,
        S_POS   = 11'b000_1000_0000,
        S_PROD  = 11'b001_0000_0000,
        S_READ  = 11'b010_0000_0000,
        S_EMIT  = 11'b100_0000_0000
    } t_state;

    typedef struct packed {
        logic load_we;      // write the input word into the image store
        logic div_start;    // start an offset count division
        logic div_sel_y;    // division works on the y axis
        logic latch_count;  // take the finished offset count
        logic chk_restart;  // restart the walk if a counter is out of range
        logic clr_count;    // clear all walk counters
        logic rd_en;        // read the image store
        logic emit;         // load the output register and advance the walk
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
        logic walk_empty;
        logic out_free;
    } t_dp_stat;

endpackage

FILE: sv/im2col_patch_gatherer_core.sv
// ============================================================================
// im2col_patch_gatherer_core: image patch gatherer for 2-D convolution
// Loads image words into a store and walks the patch windows, giving one
// column-matrix entry for each step request unless the walk is empty.
// ============================================================================
//
//   Channel  Direction  Handshake                     Payload
//   -------  ---------  ----------------------------  ---------------------------
//   s_axis   in         s_axis_tvalid/s_axis_tready   tdata: address, word; tuser: kind
//   m_axis   out        m_axis_tvalid/m_axis_tready   tdata: word, row, column;
//                                                     tuser: padded; tlast: last entry
//   cfg      in         i_cfg_valid/o_cfg_ready       register index, write data
//
// A load request writes the store while the controller is idle. A step request
// passes through the controller sequence (check, three arithmetic stages, store
// read, output). The first step after reset or a configuration write first runs
// the shared iterative divider, which produces the two offset counts.
// Reset is synchronous; the image store is not cleared and holds whatever it
// held. A full output register holds the controller in its output state until
// the result is taken; the input is ready only while the controller is idle.
// ============================================================================
module im2col_patch_gatherer_core #(
    parameter int IMAGE_WORDS = 4096,
    parameter int DATA_BITS   = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Input requests.
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // tdata: load_address [11:0], load_word [43:12], zero [47:44]
    input  logic [im2col_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // tuser: cmd
    input  logic                                  s_axis_tuser,
    // Results.
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // tdata: column_word [31:0], column_row [45:32], column_index [61:46], zero [63:62]
    output logic [im2col_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // tuser: padded
    output logic                                  m_axis_tuser,
    output logic                                  m_axis_tlast,
    // Configuration writes.
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [im2col_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [im2col_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    im2col_pkg::t_dp_cmd           cmd;
    im2col_pkg::t_dp_stat          stat;
    logic [im2col_pkg::WORD_W-1:0] out_word;
    logic [im2col_pkg::ROW_W-1:0]  out_row;
    logic [im2col_pkg::COL_W-1:0]  out_col;

    assign o_cfg_ready = 1'b1;

    im2col_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_cmd   (s_axis_tuser),
        .i_cfg_we   (i_cfg_valid),
        .i_stat     (stat),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    im2col_dp #(
        .IMAGE_WORDS (IMAGE_WORDS),
        .DATA_BITS   (DATA_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_load_addr  (s_axis_tdata[11:0]),
        .i_load_word  (s_axis_tdata[43:12]),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_out_word   (out_word),
        .o_out_row    (out_row),
        .o_out_col    (out_col),
        .o_out_padded (m_axis_tuser),
        .o_out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, out_col, out_row, out_word};

endmodule

FILE: sv/im2col_ram.sv
// ============================================================================
// im2col_ram: generic single-write, single-read memory
// One write port and one read port with registered read data.
// ============================================================================
module im2col_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/im2col_div.sv
// ============================================================================
// im2col_div: iterative divider for the offset counts
// Restoring division of a 9-bit numerator by a 4-bit divisor, one quotient
// bit per cycle; o_done pulses for one cycle when the quotient is ready.
// ============================================================================
module im2col_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [im2col_pkg::CNT_W-1:0]  i_numer,
    input  logic [3:0]                    i_denom,
    output logic                          o_done,
    output logic [im2col_pkg::CNT_W-1:0]  o_quot
);

    logic                         r_busy, n_busy;
    logic                         r_done, n_done;
    logic [3:0]                   r_cnt, n_cnt;
    logic [3:0]                   r_rem, n_rem;
    logic [3:0]                   r_den, n_den;
    logic [im2col_pkg::CNT_W-1:0] r_num, n_num;
    logic [4:0]                   rem_sh;
    logic                         q_bit;

    always_comb begin
        rem_sh = {r_rem, r_num[im2col_pkg::CNT_W-1]};
        q_bit  = (rem_sh >= {1'b0, r_den});
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_den  = r_den;
        n_num  = r_num;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_den  = i_denom;
            n_num  = i_numer;
        end else if (r_busy) begin
            n_rem = q_bit ? 4'(rem_sh - {1'b0, r_den}) : rem_sh[3:0];
            n_num = {r_num[im2col_pkg::CNT_W-2:0], q_bit};
            n_cnt = r_cnt + 4'd1;
            if (r_cnt == 4'(im2col_pkg::DIV_STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_den <= n_den;
        r_num <= n_num;
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

FILE: sv/im2col_dp.sv
// ============================================================================
// im2col_dp: datapath of the im2col patch gatherer
// Configuration registers, offset counts, walk counters, the position and
// address pipeline, the image store and the output register.
// ============================================================================
module im2col_dp #(
    parameter int IMAGE_WORDS = 4096,
    parameter int DATA_BITS   = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    input  logic [im2col_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [im2col_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic [im2col_pkg::LOAD_ADDR_W-1:0]   i_load_addr,
    input  logic [im2col_pkg::WORD_W-1:0]        i_load_word,
    input  im2col_pkg::t_dp_cmd                  i_cmd,
    output im2col_pkg::t_dp_stat                 o_stat,
    input  logic                                 i_out_ready,
    output logic                                 o_out_valid,
    output logic [im2col_pkg::WORD_W-1:0]        o_out_word,
    output logic [im2col_pkg::ROW_W-1:0]         o_out_row,
    output logic [im2col_pkg::COL_W-1:0]         o_out_col,
    output logic                                 o_out_padded,
    output logic                                 o_out_last
);

    localparam int AW         = $clog2(IMAGE_WORDS);
    localparam int STORE_BITS = (DATA_BITS < 32) ? DATA_BITS : 32;
    localparam int CW         = im2col_pkg::CNT_W;

    // Configuration registers.
    logic [8:0] r_cfg_w, r_cfg_h;
    logic [3:0] r_cfg_pw, r_cfg_ph;
    logic [6:0] r_cfg_ch;
    logic [4:0] r_cfg_ww, r_cfg_wh;
    logic [7:0] r_cfg_stride;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w      <= 9'd1;
            r_cfg_h      <= 9'd1;
            r_cfg_pw     <= '0;
            r_cfg_ph     <= '0;
            r_cfg_ch     <= 7'd1;
            r_cfg_ww     <= 5'd1;
            r_cfg_wh     <= 5'd1;
            r_cfg_stride <= 8'd17;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                im2col_pkg::CFG_IMAGE_WIDTH:   r_cfg_w      <= i_cfg_data;
                im2col_pkg::CFG_IMAGE_HEIGHT:  r_cfg_h      <= i_cfg_data;
                im2col_pkg::CFG_PAD_WIDTH:     r_cfg_pw     <= i_cfg_data[3:0];
                im2col_pkg::CFG_PAD_HEIGHT:    r_cfg_ph     <= i_cfg_data[3:0];
                im2col_pkg::CFG_CHANNEL_COUNT: r_cfg_ch     <= i_cfg_data[6:0];
                im2col_pkg::CFG_WINDOW_WIDTH:  r_cfg_ww     <= i_cfg_data[4:0];
                im2col_pkg::CFG_WINDOW_HEIGHT: r_cfg_wh     <= i_cfg_data[4:0];
                im2col_pkg::CFG_STRIDE_PAIR:   r_cfg_stride <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Saturated sizes and the two stride fields.
    logic [8:0] w, h;
    logic [6:0] ch;
    logic [4:0] ww, wh;
    logic [3:0] sx, sy;

    assign w  = (r_cfg_w  > im2col_pkg::DIM_MAX) ? im2col_pkg::DIM_MAX : r_cfg_w;
    assign h  = (r_cfg_h  > im2col_pkg::DIM_MAX) ? im2col_pkg::DIM_MAX : r_cfg_h;
    assign ch = (r_cfg_ch > im2col_pkg::CH_MAX)  ? im2col_pkg::CH_MAX  : r_cfg_ch;
    assign ww = (r_cfg_ww > im2col_pkg::WIN_MAX) ? im2col_pkg::WIN_MAX : r_cfg_ww;
    assign wh = (r_cfg_wh > im2col_pkg::WIN_MAX) ? im2col_pkg::WIN_MAX : r_cfg_wh;
    assign sx = r_cfg_stride[3:0];
    assign sy = r_cfg_stride[7:4];

    // Products that depend on the configuration alone.
    logic [8:0]  r_wwh;
    logic [16:0] r_whc;
    logic [9:0]  wwh_full;
    logic [17:0] whc_full;

    assign wwh_full = {5'b0, ww} * {5'b0, wh};
    assign whc_full = {9'b0, w} * {9'b0, h};

    always_ff @(posedge i_clk) begin
        r_wwh <= wwh_full[8:0];
        r_whc <= whc_full[16:0];
    end

    // Offset counts: ceil(span / stride) through the shared divider.
    logic signed [10:0] span_x, span_y;
    logic [9:0]         numer_x, numer_y;
    logic               zero_x, zero_y;
    logic [CW-1:0]      div_numer, div_quot;
    logic [3:0]         div_denom;
    logic               div_done;
    logic [CW-1:0]      r_nx, r_ny;

    assign span_x = $signed({2'b0, w}) + $signed({6'b0, r_cfg_pw, 1'b0})
                  - $signed({6'b0, ww}) + 11'sd1;
    assign span_y = $signed({2'b0, h}) + $signed({6'b0, r_cfg_ph, 1'b0})
                  - $signed({6'b0, wh}) + 11'sd1;
    assign numer_x = {1'b0, span_x[8:0]} + {6'b0, sx} - 10'd1;
    assign numer_y = {1'b0, span_y[8:0]} + {6'b0, sy} - 10'd1;
    assign zero_x  = (sx == 4'd0) || span_x[10] || (span_x == 11'sd0);
    assign zero_y  = (sy == 4'd0) || span_y[10] || (span_y == 11'sd0);

    assign div_numer = i_cmd.div_sel_y ? numer_y[CW-1:0] : numer_x[CW-1:0];
    assign div_denom = i_cmd.div_sel_y ? sy : sx;

    im2col_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_numer (div_numer),
        .i_denom (div_denom),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nx <= '0;
            r_ny <= '0;
        end else if (i_cmd.latch_count) begin
            if (i_cmd.div_sel_y) begin
                r_ny <= zero_y ? '0 : div_quot;
            end else begin
                r_nx <= zero_x ? '0 : div_quot;
            end
        end
    end

    // Walk counters.
    logic [8:0] r_oy, n_oy;
    logic [8:0] r_ox, n_ox;
    logic [5:0] r_cc, n_cc;
    logic [3:0] r_wr, n_wr;
    logic [3:0] r_wc, n_wc;
    logic       out_of_range, last, walk_empty;

    assign walk_empty = (r_nx == '0) || (r_ny == '0) || (ch == '0)
                      || (ww == '0) || (wh == '0);
    assign out_of_range = (r_oy >= r_ny) || (r_ox >= r_nx) || ({1'b0, r_cc} >= ch)
                        || ({1'b0, r_wr} >= wh) || ({1'b0, r_wc} >= ww);
    assign last = (r_oy == r_ny - 9'd1) && (r_ox == r_nx - 9'd1)
                && ({1'b0, r_cc} == ch - 7'd1) && ({1'b0, r_wr} == wh - 5'd1)
                && ({1'b0, r_wc} == ww - 5'd1);

    always_comb begin
        n_oy = r_oy;
        n_ox = r_ox;
        n_cc = r_cc;
        n_wr = r_wr;
        n_wc = r_wc;
        priority if (i_cmd.clr_count || (i_cmd.chk_restart && out_of_range)
                     || (i_cmd.emit && last)) begin
            n_oy = '0;
            n_ox = '0;
            n_cc = '0;
            n_wr = '0;
            n_wc = '0;
        end else if (i_cmd.emit) begin
            // Innermost counter first; each carry moves one level out.
            if ({1'b0, r_wc} + 5'd1 >= ww) begin
                n_wc = '0;
                if ({1'b0, r_wr} + 5'd1 >= wh) begin
                    n_wr = '0;
                    if ({1'b0, r_cc} + 7'd1 >= ch) begin
                        n_cc = '0;
                        if (r_ox + 9'd1 >= r_nx) begin
                            n_ox = '0;
                            n_oy = r_oy + 9'd1;
                        end else begin
                            n_ox = r_ox + 9'd1;
                        end
                    end else begin
                        n_cc = r_cc + 6'd1;
                    end
                end else begin
                    n_wr = r_wr + 4'd1;
                end
            end else begin
                n_wc = r_wc + 4'd1;
            end
        end else begin
            n_wc = r_wc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oy <= '0;
            r_ox <= '0;
            r_cc <= '0;
            r_wr <= '0;
            r_wc <= '0;
        end else begin
            r_oy <= n_oy;
            r_ox <= n_ox;
            r_cc <= n_cc;
            r_wr <= n_wr;
            r_wc <= n_wc;
        end
    end

    // First stage: positions in the padded image, row and column parts.
    logic [12:0] r_ypos, r_xpos;
    logic [8:0]  r_rowpart;
    logic [13:0] r_chrow;
    logic [15:0] r_colidx;
    logic [5:0]  r_c1;
    logic [12:0] ymul, xmul;
    logic [8:0]  rmul;
    logic [14:0] cmul;
    logic [17:0] omul;

    assign ymul = {4'b0, r_oy} * {9'b0, sy};
    assign xmul = {4'b0, r_ox} * {9'b0, sx};
    assign rmul = {5'b0, r_wr} * {4'b0, ww};
    assign cmul = {9'b0, r_cc} * {6'b0, r_wwh};
    assign omul = {9'b0, r_oy} * {9'b0, r_nx};

    always_ff @(posedge i_clk) begin
        r_ypos    <= ymul + {9'b0, r_wr};
        r_xpos    <= xmul + {9'b0, r_wc};
        r_rowpart <= rmul + {5'b0, r_wc};
        r_chrow   <= cmul[13:0];
        r_colidx  <= 16'(omul + {9'b0, r_ox});
        r_c1      <= r_cc;
    end

    // Second stage: remove the padding and test the image bounds.
    logic signed [13:0] py, px;
    logic               in_image;
    logic [7:0]         r_py8, r_px8;
    logic               r_inside;
    logic [13:0]        r_row;
    logic [22:0]        r_chaddr;
    logic [22:0]        chaddr;

    assign py = $signed({1'b0, r_ypos}) - $signed({10'b0, r_cfg_ph});
    assign px = $signed({1'b0, r_xpos}) - $signed({10'b0, r_cfg_pw});
    assign in_image = !py[13] && (py[12:0] < {4'b0, h})
                   && !px[13] && (px[12:0] < {4'b0, w});
    assign chaddr = {17'b0, r_c1} * {6'b0, r_whc};

    always_ff @(posedge i_clk) begin
        r_py8    <= py[7:0];
        r_px8    <= px[7:0];
        r_inside <= in_image;
        r_row    <= {5'b0, r_rowpart} + r_chrow;
        r_chaddr <= chaddr;
    end

    // Third stage: row offset within the channel plane.
    logic [16:0] r_pyw;

    always_ff @(posedge i_clk) begin
        r_pyw <= {9'b0, r_py8} * {8'b0, w};
    end

    // Image store.
    logic [23:0]           rd_addr;
    logic                  rd_ok;
    logic                  r_rd_ok;
    logic                  load_ok;
    logic [STORE_BITS-1:0] rdata;

    assign rd_addr = {16'b0, r_px8} + {7'b0, r_pyw} + {1'b0, r_chaddr};
    assign rd_ok   = r_inside && (rd_addr < 24'(IMAGE_WORDS));
    assign load_ok = ({5'b0, i_load_addr} < 17'(IMAGE_WORDS));

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_ok <= rd_ok;
        end
    end

    im2col_ram #(
        .WIDTH (STORE_BITS),
        .DEPTH (IMAGE_WORDS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load_we && load_ok),
        .i_waddr (AW'(i_load_addr)),
        .i_wdata (i_load_word[STORE_BITS-1:0]),
        .i_re    (i_cmd.rd_en),
        .i_raddr (AW'(rd_addr)),
        .o_rdata (rdata)
    );

    // Output register.
    logic                         r_out_valid;
    logic [im2col_pkg::WORD_W-1:0] r_out_word;
    logic [im2col_pkg::ROW_W-1:0]  r_out_row;
    logic [im2col_pkg::COL_W-1:0]  r_out_col;
    logic                         r_out_padded;
    logic                         r_out_last;
    logic                         out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.emit) begin
            r_out_word   <= r_rd_ok ? im2col_pkg::WORD_W'(rdata) : '0;
            r_out_row    <= r_row;
            r_out_col    <= r_colidx;
            r_out_padded <= !r_inside;
            r_out_last   <= last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_word   = r_out_word;
    assign o_out_row    = r_out_row;
    assign o_out_col    = r_out_col;
    assign o_out_padded = r_out_padded;
    assign o_out_last   = r_out_last;

    assign o_stat.div_done   = div_done;
    assign o_stat.walk_empty = walk_empty;
    assign o_stat.out_free   = out_free;

endmodule

FILE: sv/im2col_ctrl.sv
// ============================================================================
// im2col_ctrl: controller of the im2col patch gatherer
// Accepts requests, recomputes the offset counts after a configuration
// change and steps the datapath through one gather entry at a time.
// ============================================================================
module im2col_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_cmd,
    input  logic                  i_cfg_we,
    input  im2col_pkg::t_dp_stat  i_stat,
    output logic                  o_in_ready,
    output im2col_pkg::t_dp_cmd   o_cmd
);

    im2col_pkg::t_state r_state, n_state;
    logic               r_dirty, n_dirty;
    logic               accept;

    assign o_in_ready = (r_state == im2col_pkg::S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        n_dirty = r_dirty;
        o_cmd   = '0;
        if (i_cfg_we) begin
            n_dirty = 1'b1;
        end
        unique case (r_state)
            im2col_pkg::S_IDLE: begin
                o_cmd.load_we = accept && (i_in_cmd == im2col_pkg::CMD_LOAD);
                if (accept && (i_in_cmd == im2col_pkg::CMD_STEP)) begin
                    n_state = r_dirty ? im2col_pkg::S_DIVX : im2col_pkg::S_CHECK;
                end
            end
            im2col_pkg::S_DIVX: begin
                o_cmd.div_start = 1'b1;
                n_state         = im2col_pkg::S_WAITX;
            end
            im2col_pkg::S_WAITX: begin
                if (i_stat.div_done) begin
                    o_cmd.latch_count = 1'b1;
                    n_state           = im2col_pkg::S_DIVY;
                end
            end
            im2col_pkg::S_DIVY: begin
                o_cmd.div_sel_y = 1'b1;
                o_cmd.div_start = 1'b1;
                n_state         = im2col_pkg::S_WAITY;
            end
            im2col_pkg::S_WAITY: begin
                o_cmd.div_sel_y = 1'b1;
                if (i_stat.div_done) begin
                    o_cmd.latch_count = 1'b1;
                    n_dirty           = 1'b0;
                    n_state           = im2col_pkg::S_CHECK;
                end
            end
            im2col_pkg::S_CHECK: begin
                // An empty walk emits nothing and leaves the counters cleared.
                if (i_stat.walk_empty) begin
                    o_cmd.clr_count = 1'b1;
                    n_state         = im2col_pkg::S_IDLE;
                end else begin
                    o_cmd.chk_restart = 1'b1;
                    n_state           = im2col_pkg::S_MUL;
                end
            end
            im2col_pkg::S_MUL:  n_state = im2col_pkg::S_POS;
            im2col_pkg::S_POS:  n_state = im2col_pkg::S_PROD;
            im2col_pkg::S_PROD: n_state = im2col_pkg::S_READ;
            im2col_pkg::S_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state     = im2col_pkg::S_EMIT;
            end
            im2col_pkg::S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = im2col_pkg::S_IDLE;
                end
            end
            default: n_state = im2col_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= im2col_pkg::S_IDLE;
            r_dirty <= 1'b1;
        end else begin
            r_state <= n_state;
            r_dirty <= n_dirty;
        end
    end

endmodule
